// ===== design/selection_sort_defines.svh =====
// assertion macros shared by the sorter top level
// expects clk_i and rst_ni in the scope of each use
`ifndef SELECTION_SORT_DEFINES_SVH
`define SELECTION_SORT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ss_pkg.sv =====
// shared types and sizes for the selection sorter
// no dependencies
package ss_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]              count_t;

  typedef enum logic [2:0] {
    S_LOAD   = 3'b001,
    S_SETTLE = 3'b010,
    S_DRAIN  = 3'b100
  } state_e;

endpackage

// ===== design/ss_in_if.sv =====
// input stream of the sorter: one value per beat, last marks the batch end
// depends on ss_pkg
interface ss_in_if;
  import ss_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;
  logic   last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== design/ss_out_if.sv =====
// output stream of the sorter: one sorted value per beat
// depends on ss_pkg
interface ss_out_if;
  import ss_pkg::*;

  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   final_res;
  logic   overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflow,
                  output ready);
endinterface

// ===== design/ss_cell.sv =====
// one cell of the sorting chain: keeps the smaller value, passes the larger on
// shifts toward the head of the chain while the batch drains; depends on ss_pkg
module ss_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  logic           in_vld_i,
  input  ss_pkg::value_t in_val_i,
  input  logic           nxt_vld_i,
  input  ss_pkg::value_t nxt_val_i,
  output logic           fwd_vld_o,
  output ss_pkg::value_t fwd_val_o,
  output logic           st_vld_o,
  output ss_pkg::value_t st_val_o
);
  import ss_pkg::*;

  logic   st_vld_q, st_vld_d;
  value_t st_val_q, st_val_d;
  logic   fwd_vld_q, fwd_vld_d;
  value_t fwd_val_q, fwd_val_d;

  always_comb begin
    st_vld_d  = st_vld_q;
    st_val_d  = st_val_q;
    fwd_vld_d = 1'b0;
    fwd_val_d = fwd_val_q;
    if (shift_i) begin
      st_vld_d = nxt_vld_i;
      st_val_d = nxt_val_i;
    end else if (in_vld_i) begin
      if (!st_vld_q) begin
        st_vld_d = 1'b1;
        st_val_d = in_val_i;
      end else if (in_val_i < st_val_q) begin
        // newcomer is smaller: keep it, push the old one down the chain
        st_val_d  = in_val_i;
        fwd_vld_d = 1'b1;
        fwd_val_d = st_val_q;
      end else begin
        fwd_vld_d = 1'b1;
        fwd_val_d = in_val_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      st_vld_q  <= st_vld_d;
      fwd_vld_q <= fwd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_val_q  <= st_val_d;
    fwd_val_q <= fwd_val_d;
  end

  assign fwd_vld_o = fwd_vld_q;
  assign fwd_val_o = fwd_val_q;
  assign st_vld_o  = st_vld_q;
  assign st_val_o  = st_val_q;

endmodule

// ===== design/selection_sort.sv =====
// Batch sorter built as a chain of CAPACITY compare-and-pass cells. While a batch
// loads, one value is taken every cycle; each arriving value ripples down the chain
// one cell per cycle, every cell keeping the smaller value. Values past CAPACITY are
// dropped and flag every result of the batch with overflow. After the last beat the
// block waits in the settle state for the final value to settle in the chain, then
// sends the batch in ascending order, one result per cycle while the sink is ready,
// from the head cell while the chain shifts toward it. The next batch loads after
// the final result leaves.
// depends on ss_pkg, ss_in_if, ss_out_if, ss_cell and selection_sort_defines.svh
`include "selection_sort_defines.svh"

module selection_sort (
  input  logic     clk_i,
  input  logic     rst_ni,
  ss_in_if.sink    in_i,
  ss_out_if.source out_o
);
  import ss_pkg::*;

  state_e state_q, state_d;
  count_t cnt_q, cnt_d;
  count_t settle_q, settle_d;
  logic   dropped_q, dropped_d;

  logic   in_acc, out_acc, room, shift;

  logic   fwd_vld [CAPACITY+1];
  value_t fwd_val [CAPACITY+1];
  logic   st_vld  [CAPACITY+1];
  value_t st_val  [CAPACITY+1];

  assign in_i.ready = (state_q == S_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_o.valid = (state_q == S_DRAIN);
  assign out_acc    = out_o.valid && out_o.ready;
  assign room       = (cnt_q < count_t'(CAPACITY));
  assign shift      = out_acc;

  assign fwd_vld[0]      = in_acc && room;
  assign fwd_val[0]      = in_i.value;
  assign st_vld[CAPACITY] = 1'b0;
  assign st_val[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ss_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (shift),
      .in_vld_i  (fwd_vld[i]),
      .in_val_i  (fwd_val[i]),
      .nxt_vld_i (st_vld[i+1]),
      .nxt_val_i (st_val[i+1]),
      .fwd_vld_o (fwd_vld[i+1]),
      .fwd_val_o (fwd_val[i+1]),
      .st_vld_o  (st_vld[i]),
      .st_val_o  (st_val[i])
    );
  end

  assign out_o.sorted_value = st_val[0];
  assign out_o.final_res    = (cnt_q == count_t'(1));
  assign out_o.overflow     = dropped_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    settle_d  = settle_q;
    dropped_d = dropped_q;
    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (room) begin
            cnt_d = cnt_q + count_t'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (in_i.last) begin
            state_d  = S_SETTLE;
            settle_d = count_t'(CAPACITY);
          end
        end
      end
      S_SETTLE: begin
        // the last value may still be rippling down the chain to find its place
        if (settle_q == '0) begin
          state_d = S_DRAIN;
        end else begin
          settle_d = settle_q - count_t'(1);
        end
      end
      S_DRAIN: begin
        if (out_acc) begin
          cnt_d = cnt_q - count_t'(1);
          if (cnt_q == count_t'(1)) begin
            state_d   = S_LOAD;
            dropped_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      cnt_q     <= '0;
      settle_q  <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      settle_q  <= settle_d;
      dropped_q <= dropped_d;
    end
  end

  `SS_ASSERT_NOW(a_head_valid, out_o.valid, st_vld[0], "draining an empty head cell")
  `SS_ASSERT_NOW(a_chain_end, 1'b1, !fwd_vld[CAPACITY], "value pushed off the chain end")
  `SS_ASSERT_NOW(a_no_overlap, in_i.ready, !out_o.valid, "load and drain overlap")
  `SS_ASSERT_NEXT(a_batch_done, out_acc && out_o.final_res,
                  cnt_q == '0 && !dropped_q && !st_vld[0], "batch state not cleared")

endmodule

// ===== dv/selection_sort_tb.sv =====
// self-checking testbench for the selection_sort batch sorter
// depends on ss_pkg, ss_in_if, ss_out_if and the selection_sort rtl
`timescale 1ns / 100ps

module selection_sort_tb;
  import ss_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned RANDOM_BEATS = 250;
  localparam value_t      VAL_MIN      = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam value_t      VAL_MAX      = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t      Q_ONE        = value_t'(32'sh0001_0000);

  typedef struct {
    value_t sorted_value;
    logic   final_res;
    logic   overflow;
  } sorted_beat_t;

  // keeps the open batch in ascending order as it loads
  class sorted_scoreboard;
    value_t       batch_q[$];
    bit           dropped;
    sorted_beat_t expected_q[$];
    int           failures;

    function void note_input(value_t v, logic last);
      int pos;
      sorted_beat_t b;
      pos = 0;
      if (batch_q.size() < CAPACITY) begin
        while (pos < batch_q.size() && batch_q[pos] <= v) pos++;
        batch_q.insert(pos, v);
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        foreach (batch_q[i]) begin
          b.sorted_value = batch_q[i];
          b.final_res    = (i == batch_q.size() - 1);
          b.overflow     = dropped;
          expected_q.push_back(b);
        end
        batch_q.delete();
        dropped = 1'b0;
      end
    endfunction

    function void check_result(value_t v, logic fin, logic ovf);
      sorted_beat_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: sorted_value %0d final_res %b overflow %b", v, fin, ovf);
        failures++;
        return;
      end
      e = expected_q.pop_front();
      if (v !== e.sorted_value) begin
        $error("sorted_value: expected %0d, got %0d", e.sorted_value, v);
        failures++;
      end
      if (fin !== e.final_res) begin
        $error("final_res: expected %b, got %b", e.final_res, fin);
        failures++;
      end
      if (ovf !== e.overflow) begin
        $error("overflow: expected %b, got %b", e.overflow, ovf);
        failures++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   gaps_on;
  int unsigned beats_sent;
  int unsigned quiet_cycles;
  sorted_scoreboard sb;

  ss_in_if  in_if ();
  ss_out_if out_if ();

  selection_sort u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // one input beat, held until the handshake
  task automatic send_beat(value_t v, logic last);
    while (gaps_on && $urandom_range(0, 99) < 18) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    in_if.last  <= last;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(v, last);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // hold the sender off until every batch has drained
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3:    return value_t'($signed($urandom_range(0, 7)) - 4);
      default: return value_t'($urandom);
    endcase
  endfunction

  task automatic send_batch(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_beat(pick_value(), i == n - 1);
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= !(gaps_on && $urandom_range(0, 99) < 18);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.sorted_value, out_if.final_res, out_if.overflow);
  end

  // ends the run if the block stops moving beats
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned batch_no;
    int unsigned n;
    sb           = new();
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    in_if.last   = 1'b0;
    out_if.ready = 1'b0;
    gaps_on      = 1'b1;
    beats_sent   = 0;
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // single-value batches at both extremes
    send_beat(VAL_MIN, 1'b1);
    send_beat(VAL_MAX, 1'b1);
    // extremes, zero, unit steps and duplicates in one batch
    send_beat(VAL_MAX, 1'b0);
    send_beat(VAL_MIN, 1'b0);
    send_beat('0, 1'b0);
    send_beat(value_t'(-1), 1'b0);
    send_beat(value_t'(1), 1'b0);
    send_beat(VAL_MIN, 1'b0);
    send_beat(VAL_MAX, 1'b0);
    send_beat(Q_ONE, 1'b1);
    // descending input
    send_beat(Q_ONE * 5, 1'b0);
    send_beat(Q_ONE * 4, 1'b0);
    send_beat(Q_ONE * 3, 1'b0);
    send_beat(-Q_ONE * 2, 1'b0);
    send_beat(-Q_ONE * 7, 1'b1);
    // all equal
    send_beat(value_t'(7), 1'b0);
    send_beat(value_t'(7), 1'b0);
    send_beat(value_t'(7), 1'b1);
    // already ascending
    send_beat(value_t'(-3), 1'b0);
    send_beat(value_t'(-2), 1'b0);
    send_beat(value_t'(2), 1'b1);
    wait_drained();

    batch_no   = 0;
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      // one beat past capacity drops the last beat; exactly full fills the chain
      if (batch_no == 0)
        n = CAPACITY + 1;
      else if (batch_no == 4)
        n = CAPACITY;
      else if ($urandom_range(0, 11) == 0)
        n = $urandom_range(CAPACITY - 4, CAPACITY + 4);
      else
        n = $urandom_range(1, 8);
      gaps_on = !(beats_sent >= 100 && beats_sent < 180);
      send_batch(n);
      if (batch_no == 3 || $urandom_range(0, 9) == 0) wait_drained();
      batch_no++;
    end

    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2 * CAPACITY) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
